// File: src/dss_pkg.sv
// shared types, constants and helper functions of the spaced-seed histogram
`default_nettype none
package dss_pkg;

	localparam int KEY_BITS   = 12;
	localparam int COUNT_BITS = 16;
	localparam int HIST_DEPTH = 1 << KEY_BITS;
	localparam int OUT_W      = ((COUNT_BITS + 7) / 8) * 8;
	localparam int SHIFT_W    = 24;
	localparam int POS_W      = 5;
	localparam int NUM_SEEDS  = 5;
	localparam int SEED_IDX_W = $clog2(NUM_SEEDS);
	localparam int IN_W       = 24;
	localparam int FUNC_W     = 2;

	// seed selection masks over the base shift register, newest base lowest
	localparam logic [SHIFT_W-1:0] SEED_MASK [NUM_SEEDS] = '{
		24'h03B2D7, 24'h3C44D7, 24'h000FFF, 24'h1A18AF, 24'h007747
	};

	// a seed fires once the character index is above its threshold
	localparam logic [POS_W-1:0] SEED_THR [NUM_SEEDS] = '{
		5'd18, 5'd22, 5'd12, 5'd21, 5'd15
	};

	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH  = 2'd0,
		FN_READ  = 2'd1,
		FN_CLEAR = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SEED,
		ST_INCR,
		ST_RDOUT
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic accept_push;
		logic accept_read;
		logic accept_clear;
		logic seed_rd;
		logic incr_wr;
		logic clr_wr;
		logic load_out;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic pend_any;
		logic clr_last;
		logic out_free;
	} stat_t;

	// character to {unknown, code}
	function automatic logic [2:0] base_code(input logic [7:0] ch);
		logic [2:0] r;
		case (ch) inside
			8'h61, 8'h41: r = 3'b000;
			8'h74, 8'h54: r = 3'b001;
			8'h63, 8'h43: r = 3'b010;
			8'h67, 8'h47: r = 3'b011;
			default:      r = 3'b100;
		endcase
		return r;
	endfunction

	// compact the selected base bits of one seed into a key
	function automatic logic [KEY_BITS-1:0] seed_key(input logic [SEED_IDX_W-1:0] s,
			input logic [SHIFT_W-1:0] b);
		logic [KEY_BITS-1:0] k;
		case (s)
			3'd0:    k = {b[17:15], b[13:12], b[9], b[7:6], b[4], b[2:0]};
			3'd1:    k = {b[21:18], b[14], b[10], b[7:6], b[4], b[2:0]};
			3'd3:    k = {1'b0, b[20:19], b[17], b[12:11], b[7], b[5], b[3:0]};
			3'd4:    k = {2'b00, b[14:12], b[10:8], b[6], b[2:0]};
			default: k = b[11:0];
		endcase
		return k;
	endfunction

endpackage
`default_nettype wire

// File: src/dss_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none
module dss_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data held while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: src/dss_ctrl.sv
// controller state machine of the spaced-seed histogram
`default_nettype none
module dss_ctrl import dss_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [FUNC_W-1:0] in_func,
	output      logic              in_ready,
	input  wire stat_t             stat,
	output      cmd_t              cmd
);

	state_t state_q, state_d;
	logic   acc;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign acc      = in_valid && in_ready;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (acc) begin
					case (in_func)
						FN_PUSH: begin
							cmd.accept_push = 1'b1;
							state_d = ST_SEED;
						end
						FN_READ: begin
							cmd.accept_read = 1'b1;
							state_d = ST_RDOUT;
						end
						FN_CLEAR: begin
							cmd.accept_clear = 1'b1;
							state_d = ST_CLEAR;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_SEED: begin
				if (stat.pend_any) begin
					cmd.seed_rd = 1'b1;
					state_d = ST_INCR;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_INCR: begin
				cmd.incr_wr = 1'b1;
				state_d = stat.pend_any ? ST_SEED : ST_IDLE;
			end
			ST_RDOUT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: src/dss_dp.sv
// datapath: shift state, seed keys, histogram memory and output register
`default_nettype none
module dss_dp import dss_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire cmd_t            cmd,
	output      stat_t           stat,
	input  wire logic [IN_W-1:0] in_data,
	input  wire logic            out_ready,
	output      logic            out_valid,
	output      logic [OUT_W-1:0] out_data
);

	logic [SHIFT_W-1:0]    base_q, unk_q;
	logic [POS_W-1:0]      pos_q;
	logic [NUM_SEEDS-1:0]  pend_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [KEY_BITS-1:0]   clr_cnt_q;
	logic                  out_valid_q;
	logic [COUNT_BITS-1:0] out_q;

	logic [7:0]            base_char;
	logic [KEY_BITS-1:0]   read_key;
	logic [2:0]            code;
	logic [SHIFT_W-1:0]    base_new, unk_new;
	logic [NUM_SEEDS-1:0]  fire;
	logic [SEED_IDX_W-1:0] sel;
	logic [KEY_BITS-1:0]   sel_key;

	logic                  ram_we, ram_re;
	logic [KEY_BITS-1:0]   ram_waddr, ram_raddr;
	logic [COUNT_BITS-1:0] ram_wdata, ram_rdata, inc;

	assign base_char = in_data[7:0];
	assign read_key  = in_data[8 +: KEY_BITS];

	// shifted state after a pushed character
	assign code     = base_code(base_char);
	assign base_new = {base_q[SHIFT_W-3:0], (code[2] ? 2'b00 : code[1:0])};
	assign unk_new  = {unk_q[SHIFT_W-3:0], (code[2] ? 2'b11 : 2'b00)};

	// seeds that fire on the new state
	always_comb begin
		for (int i = 0; i < NUM_SEEDS; i++) begin
			fire[i] = ((unk_new & SEED_MASK[i]) == '0) && (pos_q > SEED_THR[i]);
		end
	end

	// lowest pending seed is served first
	always_comb begin
		sel = '0;
		for (int i = NUM_SEEDS - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				sel = SEED_IDX_W'(i);
			end
		end
	end

	assign sel_key = seed_key(sel, base_q);

	// shift state, position and pending seeds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			unk_q  <= '0;
			pos_q  <= '0;
			pend_q <= '0;
		end else if (cmd.accept_clear) begin
			base_q <= '0;
			unk_q  <= '0;
			pos_q  <= '0;
			pend_q <= '0;
		end else if (cmd.accept_push) begin
			base_q <= base_new;
			unk_q  <= unk_new;
			pend_q <= fire;
			if (pos_q != '1) begin
				pos_q <= pos_q + 1'b1;
			end
		end else if (cmd.seed_rd) begin
			pend_q[sel] <= 1'b0;
		end
	end

	// key under read-modify-write
	always_ff @(posedge clk) begin
		if (cmd.seed_rd) begin
			key_q <= sel_key;
		end
	end

	// clearing sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.accept_clear) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// saturating increment
	assign inc = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;

	// memory port selection
	assign ram_re    = cmd.seed_rd || cmd.accept_read;
	assign ram_raddr = cmd.seed_rd ? sel_key : read_key;
	assign ram_we    = cmd.clr_wr || cmd.incr_wr;
	assign ram_waddr = cmd.clr_wr ? clr_cnt_q : key_q;
	assign ram_wdata = cmd.clr_wr ? '0 : inc;

	dss_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(HIST_DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= ram_rdata;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_data      = OUT_W'(out_q);
	assign stat.pend_any = |pend_q;
	assign stat.clr_last = (clr_cnt_q == '1);
	assign stat.out_free = !out_valid_q || out_ready;

endmodule
`default_nettype wire

// File: src/dna_spaced_seed_histogram.sv
// top level of the spaced-seed k-mer histogram
// After a push transfer s_tready stays low while each of the five seeds that fires does
// a read then a write of the single 4096 x 16 histogram memory, lowest seed first. After
// a read transfer s_tready stays low until the count is loaded, which is held only if the
// previous count has not yet been taken. After reset and after a start-new-sequence
// transfer the block clears every histogram entry, one entry a cycle, with s_tready low;
// a count read after a push sees every update of that push.
`default_nettype none
module dna_spaced_seed_histogram import dss_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output      logic              s_tready,
	input  wire logic [IN_W-1:0]   s_tdata,   // base_char[7:0], read_key[19:8], zero fill
	input  wire logic [FUNC_W-1:0] s_tuser,   // func[1:0]
	output      logic              m_tvalid,
	input  wire logic              m_tready,
	output      logic [OUT_W-1:0]  m_tdata    // read_count[15:0]
);

	cmd_t  cmd;
	stat_t stat;

	dss_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_func (s_tuser),
		.in_ready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	dss_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_data  (s_tdata),
		.out_ready(m_tready),
		.out_valid(m_tvalid),
		.out_data (m_tdata)
	);

endmodule
`default_nettype wire

// File: src/dss_chk.sv
// port-level checker of the spaced-seed histogram and its bind
`default_nettype none
module dss_chk import dss_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              s_tvalid,
	input wire logic              s_tready,
	input wire logic [IN_W-1:0]   s_tdata,
	input wire logic [FUNC_W-1:0] s_tuser,
	input wire logic              m_tvalid,
	input wire logic              m_tready,
	input wire logic [OUT_W-1:0]  m_tdata
);

	logic acc;
	assign acc = s_tvalid && s_tready;

	// a stalled count holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("count changed while stalled");

	// a push never produces a count
	a_push_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		acc && s_tuser == FN_PUSH |=> !$rose(m_tvalid))
		else $error("count appeared after a push");

	// a clear starts the sweep with the input closed
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc && s_tuser == FN_CLEAR |=> !s_tready)
		else $error("input open after a clear");

	// a read keeps the input closed until its count is loaded
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc && s_tuser == FN_READ |=> !s_tready)
		else $error("input open during a read");

endmodule

bind dna_spaced_seed_histogram dss_chk u_chk (.*);
`default_nettype wire

// File: sim/tb_top.sv
// self-checking testbench of the spaced-seed k-mer histogram
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import dss_pkg::*;

	localparam logic [1:0] FN_UNUSED = 2'd3;
	localparam int         POLY_RUN  = 64;

	// seed selection masks and the index each seed must exceed
	localparam logic [23:0] SEED_SEL [5] = '{
		24'h03B2D7, 24'h3C44D7, 24'h000FFF, 24'h1A18AF, 24'h007747
	};
	localparam logic [4:0] SEED_MIN [5] = '{5'd18, 5'd22, 5'd12, 5'd21, 5'd15};

	typedef struct {
		logic [1:0]  fn;
		logic [7:0]  ch;
		logic [11:0] key;
		bit          typed;
		logic [15:0] count;
	} stim_row_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;   // base_char[7:0], read_key[19:8], zero fill
	logic [1:0]       s_tuser;   // func[1:0]
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;   // read_count[15:0]

	// model of the block state
	logic [23:0] hist_bases;
	logic [23:0] hist_unknown;
	logic [4:0]  seq_pos;
	logic [15:0] key_hist [4096];

	logic [15:0] pending_counts [$];
	logic [11:0] recent_keys [$];
	stim_row_t   directed_rows [$];
	int          err_count;
	bit          idle_on;
	int          stall_left;

	dna_spaced_seed_histogram dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// gather the selected base bits, lowest first, into a key
	function automatic logic [11:0] compact_bits(input logic [23:0] sel,
			input logic [23:0] b);
		logic [11:0] k;
		int j;
		k = '0;
		j = 0;
		for (int i = 0; i < 24; i++) begin
			if (sel[i]) begin
				k[j] = b[i];
				j++;
			end
		end
		return k;
	endfunction

	task automatic clear_model();
		hist_bases   = '0;
		hist_unknown = '0;
		seq_pos      = '0;
		for (int i = 0; i < 4096; i++)
			key_hist[i] = '0;
	endtask

	// advance the model by one accepted transfer, return the count a read sees
	task automatic apply_transfer(input logic [1:0] fn, input logic [7:0] ch,
			input logic [11:0] key, output logic [15:0] count);
		logic [1:0]  code;
		logic        unk;
		logic [11:0] k;
		count = '0;
		case (fn)
			FN_PUSH: begin
				unk = 1'b0;
				case (ch)
					"A", "a": code = 2'd0;
					"T", "t": code = 2'd1;
					"C", "c": code = 2'd2;
					"G", "g": code = 2'd3;
					default: begin
						code = 2'd0;
						unk  = 1'b1;
					end
				endcase
				hist_bases   = {hist_bases[21:0], code};
				hist_unknown = {hist_unknown[21:0], {2{unk}}};
				for (int s = 0; s < 5; s++) begin
					if ((hist_unknown & SEED_SEL[s]) == '0 && seq_pos > SEED_MIN[s]) begin
						k = compact_bits(SEED_SEL[s], hist_bases);
						if (key_hist[k] != 16'hFFFF)
							key_hist[k] = key_hist[k] + 16'd1;
						recent_keys.insert(recent_keys.size(), k);
						if (recent_keys.size() > 16)
							recent_keys.delete(0);
					end
				end
				if (seq_pos != 5'd31)
					seq_pos = seq_pos + 5'd1;
			end
			FN_READ:  count = key_hist[key];
			FN_CLEAR: clear_model();
			default: ;
		endcase
	endtask

	// present one item, wait for its transfer, then update the model
	task automatic send_item(input logic [1:0] fn, input logic [7:0] ch,
			input logic [11:0] key, input bit typed, input logic [15:0] typed_count);
		logic [15:0] count;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= fn;
		s_tdata  <= {4'b0000, key, ch};
		do @(posedge clk); while (!s_tready);
		apply_transfer(fn, ch, key, count);
		if (fn == FN_READ)
			pending_counts.insert(pending_counts.size(), typed ? typed_count : count);
	endtask

	// result side backpressure in random bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 5);
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// compare each count transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_counts.size() == 0) begin
				$display("%0t: unexpected read_count, expected none, actual %0d",
					$time, m_tdata[15:0]);
				err_count++;
			end else begin
				if (m_tdata[15:0] !== pending_counts[0]) begin
					$display("%0t: read_count mismatch, expected %0d, actual %0d",
						$time, pending_counts[0], m_tdata[15:0]);
					err_count++;
				end
				pending_counts.delete(0);
			end
		end
	end

	// hard stop
	initial begin
		#10_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		logic [1:0]  fn;
		logic [7:0]  ch;
		logic [11:0] key;
		int          r;
		string       bases;

		clk        = 1'b0;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = FN_PUSH;
		m_tready   = 1'b0;
		stall_left = 0;
		err_count  = 0;
		idle_on    = 1'b1;
		bases      = "ACGTacgt";
		clear_model();

		// empty histogram, ignored code, mixed case bases, unknowns, then a clear
		directed_rows.push_back('{FN_READ,   8'h00, 12'h000, 1'b1, 16'd0});
		directed_rows.push_back('{FN_READ,   8'hFF, 12'hFFF, 1'b1, 16'd0});
		directed_rows.push_back('{FN_UNUSED, "G",   12'hABC, 1'b0, 16'd0});
		directed_rows.push_back('{FN_PUSH,   "A",   12'hFFF, 1'b0, 16'd0});
		directed_rows.push_back('{FN_PUSH,   "t",   12'h000, 1'b0, 16'd0});
		directed_rows.push_back('{FN_PUSH,   "C",   12'h555, 1'b0, 16'd0});
		directed_rows.push_back('{FN_PUSH,   "g",   12'hAAA, 1'b0, 16'd0});
		directed_rows.push_back('{FN_PUSH,   "N",   12'h000, 1'b0, 16'd0});
		directed_rows.push_back('{FN_PUSH,   8'h00, 12'h000, 1'b0, 16'd0});
		directed_rows.push_back('{FN_PUSH,   8'hFF, 12'hFFF, 1'b0, 16'd0});
		directed_rows.push_back('{FN_PUSH,   8'h80, 12'h000, 1'b0, 16'd0});
		directed_rows.push_back('{FN_PUSH,   "a",   12'h000, 1'b0, 16'd0});
		directed_rows.push_back('{FN_PUSH,   "T",   12'h000, 1'b0, 16'd0});
		directed_rows.push_back('{FN_PUSH,   "c",   12'h000, 1'b0, 16'd0});
		directed_rows.push_back('{FN_PUSH,   "G",   12'h000, 1'b0, 16'd0});
		for (int i = 0; i < 6; i++)
			directed_rows.push_back('{FN_PUSH, "A", 12'h000, 1'b0, 16'd0});
		directed_rows.push_back('{FN_READ,   8'h00, 12'h000, 1'b0, 16'd0});
		directed_rows.push_back('{FN_READ,   8'h00, 12'hFFF, 1'b0, 16'd0});
		directed_rows.push_back('{FN_CLEAR,  8'hFF, 12'hFFF, 1'b0, 16'd0});
		directed_rows.push_back('{FN_READ,   8'h00, 12'h000, 1'b1, 16'd0});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		foreach (directed_rows[i])
			send_item(directed_rows[i].fn, directed_rows[i].ch, directed_rows[i].key,
				directed_rows[i].typed, directed_rows[i].count);

		// random part, mostly well-formed base runs with reads of live keys
		for (int n = 0; n < 800; n++) begin
			if (n % 60 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			r   = $urandom_range(0, 999);
			ch  = 8'($urandom_range(0, 255));
			key = 12'($urandom_range(0, 4095));
			if (r < 5) begin
				fn = FN_CLEAR;
			end else if (r < 12) begin
				fn = FN_UNUSED;
			end else if (r < 160) begin
				fn = FN_READ;
				if (recent_keys.size() != 0 && $urandom_range(0, 2) != 0)
					key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
			end else begin
				fn = FN_PUSH;
				if (r < 180)
					ch = ($urandom_range(0, 1) != 0) ? "N" : "n";
				else if (r >= 200)
					ch = bases[$urandom_range(0, 7)];
			end
			send_item(fn, ch, key, 1'b0, 16'd0);
		end

		// homopolymer run piles increments from every seed onto key 0, no idling
		idle_on = 1'b0;
		send_item(FN_CLEAR, 8'h00, 12'h000, 1'b0, 16'd0);
		for (int n = 0; n < POLY_RUN; n++)
			send_item(FN_PUSH, (n % 2 != 0) ? "a" : "A", 12'hFFF, 1'b0, 16'd0);
		send_item(FN_READ, 8'h00, 12'h000, 1'b0, 16'd0);
		send_item(FN_READ, 8'h00, 12'h001, 1'b0, 16'd0);
		send_item(FN_READ, 8'h00, 12'hFFF, 1'b0, 16'd0);
		s_tvalid <= 1'b0;

		// drain
		while (pending_counts.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
`default_nettype wire
